@@ rtl/bpa_pkg.sv @@
// Package for the bitmap page allocator: field widths, command, status and
// register index codes, and register reset values.
// No dependencies.
package bpa_pkg;

   localparam int ADDR_W      = 48;
   localparam int WORD_BITS   = 64;
   localparam int BIT_IDX_W   = 6;
   localparam int PAGE_WORD_W = ADDR_W - BIT_IDX_W;
   localparam int STATUS_W    = 3;
   localparam int SHIFT_W     = 5;
   localparam int WORDS_CSR_W = 9;
   localparam int CSR_DATA_W  = 9;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic CSR_PAGE_SHIFT   = 1'b0;
   localparam logic CSR_WORDS_IN_USE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_IN_USE  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NO_FREE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OUTSIDE = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NO_INIT = 3'd4;

   localparam logic [SHIFT_W-1:0]     PAGE_SHIFT_RESET   = 5'd12;
   localparam logic [WORDS_CSR_W-1:0] WORDS_IN_USE_RESET = 9'd256;

   localparam logic [WORD_BITS-1:0] FULL_WORD = '1;

   typedef logic [ADDR_W-1:0]    addr_type;
   typedef logic [WORD_BITS-1:0] word_type;

endpackage

@@ rtl/bpa_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bpa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bitmap_page_allocator_unit.sv @@
// Bitmap page allocator: used-page bitmap in RAM with a small sequencer.
// Depends on bpa_pkg and bpa_ram.
// A given-address allocate or a free reads and updates one bitmap word; an early
// status skips the read, and an any-page allocate scans the words in use (one
// word read a cycle) until it finds a free page or finds that none is free.
// One transfer at a time; the next request is taken once the result is loaded.
// Reset is synchronous; afterwards a clearing pass writes zero to every bitmap
// word, one per cycle, before requests are taken.
module bitmap_page_allocator_unit #(
   parameter int BITMAP_WORDS = 256,
   parameter int ADDRESS_BITS = 48
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_command,
   input  logic [bpa_pkg::ADDR_W-1:0]           req_address,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [bpa_pkg::ADDR_W-1:0]           rsp_result_address,
   output logic [bpa_pkg::STATUS_W-1:0]         rsp_status,
   input  logic                                 csr_write_enable,
   input  logic                                 csr_index,
   input  logic [bpa_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   localparam int WIDX  = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
   localparam int CNT_W = ($clog2(BITMAP_WORDS + 1) > bpa_pkg::WORDS_CSR_W) ?
                          $clog2(BITMAP_WORDS + 1) : bpa_pkg::WORDS_CSR_W;
   localparam int PAGE_W = WIDX + bpa_pkg::BIT_IDX_W;
   localparam logic [63:0] AMASK64 = (ADDRESS_BITS >= 64) ? 64'hffff_ffff_ffff_ffff :
                                     ((64'd1 << ADDRESS_BITS) - 64'd1);
   localparam logic [bpa_pkg::ADDR_W-1:0] AMASK = AMASK64[bpa_pkg::ADDR_W-1:0];
   localparam logic [WIDX-1:0] LAST_WORD = WIDX'(BITMAP_WORDS - 1);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DECODE = 3'd2;
   localparam logic [2:0] S_CHECK  = 3'd3;
   localparam logic [2:0] S_SCAN   = 3'd4;
   localparam logic [2:0] S_FOUND  = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0]                           state_ff, state_in;
   logic                                 cmd_ff, cmd_in;
   bpa_pkg::addr_type                    addr_ff, addr_in;
   logic [CNT_W-1:0]                     issue_ff, issue_in;
   logic [CNT_W-1:0]                     chk_ff, chk_in;
   logic                                 pend_ff, pend_in;
   logic [WIDX-1:0]                      clr_ff, clr_in;
   logic [WIDX-1:0]                      widx_ff, widx_in;
   logic [bpa_pkg::BIT_IDX_W-1:0]        bitpos_ff, bitpos_in;
   bpa_pkg::word_type                    word_ff, word_in;
   bpa_pkg::addr_type                    res_addr_ff, res_addr_in;
   logic [bpa_pkg::STATUS_W-1:0]         res_status_ff, res_status_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   bpa_pkg::addr_type                    rsp_addr_ff, rsp_addr_in;
   logic [bpa_pkg::STATUS_W-1:0]         rsp_status_ff, rsp_status_in;
   logic [bpa_pkg::SHIFT_W-1:0]          shift_ff, shift_in;
   logic [bpa_pkg::WORDS_CSR_W-1:0]      wiu_ff, wiu_in;

   logic [CNT_W-1:0]                     eff_words;
   bpa_pkg::addr_type                    page_num;
   logic [bpa_pkg::PAGE_WORD_W-1:0]      page_word;
   logic                                 outside;
   logic                                 issue_more;
   bpa_pkg::word_type                    free_bits;
   bpa_pkg::word_type                    low_free;
   logic [bpa_pkg::BIT_IDX_W-1:0]        low_pos;
   bpa_pkg::word_type                    bit_mask;
   logic [63:0]                          scan_addr;
   logic                                 slot_free;

   logic                                 ram_wr_en;
   logic [WIDX-1:0]                      ram_wr_addr;
   bpa_pkg::word_type                    ram_wr_data;
   logic                                 ram_rd_en;
   logic [WIDX-1:0]                      ram_rd_addr;
   bpa_pkg::word_type                    ram_rd_data;

   bpa_ram #(
      .WIDTH (bpa_pkg::WORD_BITS),
      .DEPTH (BITMAP_WORDS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      eff_words = (CNT_W'(wiu_ff) > CNT_W'(BITMAP_WORDS)) ? CNT_W'(BITMAP_WORDS) :
                  CNT_W'(wiu_ff);
      page_num   = addr_ff >> shift_ff;
      page_word  = page_num[bpa_pkg::ADDR_W-1:bpa_pkg::BIT_IDX_W];
      outside    = page_word >= bpa_pkg::PAGE_WORD_W'(eff_words);
      issue_more = issue_ff < eff_words;
      free_bits  = ~ram_rd_data;
      low_free   = free_bits & (~free_bits + 64'd1);
      low_pos    = '0;
      for (int i = 0; i < bpa_pkg::WORD_BITS; i++) begin
         if (low_free[i]) begin
            low_pos = low_pos | bpa_pkg::BIT_IDX_W'(i);
         end
      end
      bit_mask  = 64'd1 << bitpos_ff;
      scan_addr = 64'({widx_ff, bitpos_ff}) << shift_ff;
      slot_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      issue_in      = issue_ff;
      chk_in        = chk_ff;
      pend_in       = pend_ff;
      clr_in        = clr_ff;
      widx_in       = widx_ff;
      bitpos_in     = bitpos_ff;
      word_in       = word_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      shift_in      = shift_ff;
      wiu_in        = wiu_ff;
      req_ready     = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = widx_ff;
      ram_wr_data   = word_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = page_word[WIDX-1:0];

      if (csr_write_enable) begin
         unique case (csr_index)
            bpa_pkg::CSR_PAGE_SHIFT:   shift_in = csr_write_data[bpa_pkg::SHIFT_W-1:0];
            bpa_pkg::CSR_WORDS_IN_USE: wiu_in   = csr_write_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
            if (clr_ff == LAST_WORD) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + WIDX'(1);
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in   = req_command;
               addr_in  = req_address;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_addr_in = '0;
            if (eff_words == '0) begin
               res_status_in = bpa_pkg::ST_NO_INIT;
               state_in      = S_DONE;
            end else if (cmd_ff == bpa_pkg::CMD_ALLOC && addr_ff == '0) begin
               issue_in = '0;
               pend_in  = 1'b0;
               state_in = S_SCAN;
            end else if (outside) begin
               res_status_in = bpa_pkg::ST_OUTSIDE;
               state_in      = S_DONE;
            end else begin
               ram_rd_en = 1'b1;
               widx_in   = page_word[WIDX-1:0];
               bitpos_in = page_num[bpa_pkg::BIT_IDX_W-1:0];
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            ram_wr_addr   = widx_ff;
            res_addr_in   = '0;
            res_status_in = bpa_pkg::ST_OK;
            state_in      = S_DONE;
            if (cmd_ff == bpa_pkg::CMD_FREE) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = ram_rd_data & ~bit_mask;
            end else if ((ram_rd_data & bit_mask) != '0) begin
               res_status_in = bpa_pkg::ST_IN_USE;
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_data = ram_rd_data | bit_mask;
               res_addr_in = addr_ff & AMASK;
            end
         end
         S_SCAN: begin
            ram_rd_addr = issue_ff[WIDX-1:0];
            ram_rd_en   = issue_more;
            pend_in     = issue_more;
            chk_in      = issue_ff;
            if (issue_more) begin
               issue_in = issue_ff + CNT_W'(1);
            end
            if (pend_ff && ram_rd_data != bpa_pkg::FULL_WORD) begin
               widx_in   = chk_ff[WIDX-1:0];
               bitpos_in = low_pos;
               word_in   = ram_rd_data | low_free;
               state_in  = S_FOUND;
            end else if (pend_ff && !issue_more) begin
               res_addr_in   = '0;
               res_status_in = bpa_pkg::ST_NO_FREE;
               state_in      = S_DONE;
            end
         end
         S_FOUND: begin
            ram_wr_en     = 1'b1;
            res_addr_in   = scan_addr[bpa_pkg::ADDR_W-1:0] & AMASK;
            res_status_in = bpa_pkg::ST_OK;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         issue_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         shift_ff     <= bpa_pkg::PAGE_SHIFT_RESET;
         wiu_ff       <= bpa_pkg::WORDS_IN_USE_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         issue_ff     <= issue_in;
         rsp_valid_ff <= rsp_valid_in;
         shift_ff     <= shift_in;
         wiu_ff       <= wiu_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      chk_ff        <= chk_in;
      widx_ff       <= widx_in;
      bitpos_ff     <= bitpos_in;
      word_ff       <= word_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_status         = rsp_status_ff;

endmodule
